// ===== design/dsu_pkg.sv =====
// shared constants, types and codes for the union-find engine
`default_nettype none
package dsu_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CFG_W        = 11;
    localparam int ACT_W        = 3;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 72;

    // action codes
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNION  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd4;

    // register index of initial_count
    localparam logic REG_INIT_COUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_COMP_RD,
        S_COMP_WR,
        S_SIZE_RD,
        S_SIZE_WT1,
        S_SIZE_WT2,
        S_SWEEP,
        S_DONE
    } t_state;

    // per-action part of a result, last field lowest
    typedef struct packed {
        logic             error;
        logic [IDX_W-1:0] new_element;
        logic [CNT_W-1:0] first_set_size;
        logic             connected;
        logic [IDX_W-1:0] second_root;
        logic [IDX_W-1:0] first_root;
    } t_part;

endpackage
`default_nettype wire

// ===== design/disjoint_set_union_find.sv =====
// union-find engine: parent and size tables in ram, find with path compression
// query/union: a find of each index with compression of its path, then size reads and the result;
//   add, unknown actions and index errors go straight to the result; clear/resize first
//   re-initialise the entries in a sweep; a stalled result holds the engine in place
// one action at a time, the next accepted in the cycle after the result is loaded
// reset: synchronous active low; counters and initial_count go to zero, no entry is live
`default_nettype none
module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // action stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // action, first_index, second_index
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // first_root, second_root, connected, first_set_size, component_total,
    // multi_member_total, new_element, error
    output logic      [OUT_W-1:0]  m_axis_tdata
);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_init;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_comp, n_comp;
    logic [CNT_W-1:0] r_single, n_single;
    logic [CNT_W-1:0] r_target, n_target;
    logic [CNT_W-1:0] r_sweep, n_sweep;
    logic             r_union, n_union;
    logic             r_phase, n_phase;
    logic [IDX_W-1:0] r_first, n_first;
    logic [IDX_W-1:0] r_second, n_second;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic [IDX_W-1:0] r_root, n_root;
    logic [CNT_W-1:0] r_s1, n_s1;
    t_part            r_part, n_part;
    logic             r_m_valid, n_m_valid;
    logic [OUT_W-1:0] r_m_data, n_m_data;

    logic             p_we, s_we;
    logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [IDX_W-1:0] s_waddr, s_raddr;
    logic [CNT_W-1:0] s_wdata, s_rdata;

    logic [ACT_W-1:0] in_act;
    logic [IDX_W-1:0] in_a, in_b;
    logic             accept;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] sat_init;
    logic [CNT_W-1:0] multi;

    assign in_act = s_axis_tdata[ACT_W-1:0];
    assign in_a   = s_axis_tdata[ACT_W +: IDX_W];
    assign in_b   = s_axis_tdata[ACT_W+IDX_W +: IDX_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign sum           = r_s1 + s_rdata;
    assign sat_init      = (CNT_W'(r_init) > CNT_W'(MAX_ELEMENTS)) ?
                           CNT_W'(MAX_ELEMENTS) : CNT_W'(r_init);
    assign multi         = r_comp - r_single;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INIT_COUNT) ? {{(32-CFG_W){1'b0}}, r_init} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_INIT_COUNT) begin
            r_init <= pwdata[CFG_W-1:0];
        end
    end

    // parent and size tables
    dsu_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    dsu_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ELEMENTS)) u_size (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_comp    <= '0;
            r_single  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_comp    <= n_comp;
            r_single  <= n_single;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_sweep  <= n_sweep;
        r_union  <= n_union;
        r_phase  <= n_phase;
        r_first  <= n_first;
        r_second <= n_second;
        r_cur    <= n_cur;
        r_walk   <= n_walk;
        r_root   <= n_root;
        r_s1     <= n_s1;
        r_part   <= n_part;
        r_m_data <= n_m_data;
    end

    // sequencer: add, find walks, compression, size merge, sweep, result handoff
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_comp    = r_comp;
        n_single  = r_single;
        n_target  = r_target;
        n_sweep   = r_sweep;
        n_union   = r_union;
        n_phase   = r_phase;
        n_first   = r_first;
        n_second  = r_second;
        n_cur     = r_cur;
        n_walk    = r_walk;
        n_root    = r_root;
        n_s1      = r_s1;
        n_part    = r_part;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        p_we      = 1'b0;
        p_waddr   = r_walk;
        p_wdata   = r_root;
        p_raddr   = r_cur;
        s_we      = 1'b0;
        s_waddr   = r_root;
        s_wdata   = sum;
        s_raddr   = r_first;

        // output register drains independently
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_part  = '0;
                    n_union = (in_act == ACT_UNION);
                    n_state = S_DONE;
                    if (in_act == ACT_QUERY || in_act == ACT_UNION) begin
                        if ({1'b0, in_a} >= r_used || {1'b0, in_b} >= r_used) begin
                            n_part.error = 1'b1;
                        end else begin
                            n_first  = in_a;
                            n_second = in_b;
                            n_cur    = in_a;
                            n_phase  = 1'b0;
                            n_state  = S_FIND_RD;
                        end
                    end else if (in_act == ACT_ADD) begin
                        if (r_used >= CNT_W'(MAX_ELEMENTS)) begin
                            n_part.error = 1'b1;
                        end else begin
                            p_we               = 1'b1;
                            p_waddr            = r_used[IDX_W-1:0];
                            p_wdata            = r_used[IDX_W-1:0];
                            s_we               = 1'b1;
                            s_waddr            = r_used[IDX_W-1:0];
                            s_wdata            = CNT_W'(1);
                            n_part.new_element = r_used[IDX_W-1:0];
                            n_used             = r_used + CNT_W'(1);
                            n_comp             = r_comp + CNT_W'(1);
                            n_single           = r_single + CNT_W'(1);
                        end
                    end else if (in_act == ACT_CLEAR) begin
                        n_target = r_used;
                        n_sweep  = '0;
                        n_state  = S_SWEEP;
                    end else if (in_act == ACT_RESIZE) begin
                        n_target = sat_init;
                        n_sweep  = '0;
                        n_state  = S_SWEEP;
                    end
                end
            end
            S_FIND_RD: begin
                p_raddr = r_cur;
                n_state = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                // parent of r_cur is on the read port
                if (p_rdata == r_cur) begin
                    n_root  = r_cur;
                    n_walk  = r_phase ? r_second : r_first;
                    n_state = S_COMP_RD;
                end else begin
                    n_cur   = p_rdata;
                    p_raddr = p_rdata;
                end
            end
            S_COMP_RD: begin
                p_raddr = r_walk;
                if (r_walk == r_root) begin
                    if (!r_phase) begin
                        n_part.first_root = r_root;
                        n_phase           = 1'b1;
                        n_cur             = r_second;
                        n_state           = S_FIND_RD;
                    end else begin
                        n_part.second_root = r_root;
                        n_state            = S_SIZE_RD;
                    end
                end else begin
                    n_state = S_COMP_WR;
                end
            end
            S_COMP_WR: begin
                // point r_walk at the root and move on to its old parent
                p_we    = 1'b1;
                p_waddr = r_walk;
                p_wdata = r_root;
                n_walk  = p_rdata;
                p_raddr = p_rdata;
                if (p_rdata == r_root) begin
                    n_state = S_COMP_RD;
                end
            end
            S_SIZE_RD: begin
                s_raddr = r_part.first_root;
                n_state = S_SIZE_WT1;
            end
            S_SIZE_WT1: begin
                s_raddr = r_part.second_root;
                n_s1    = s_rdata;
                n_state = S_SIZE_WT2;
            end
            S_SIZE_WT2: begin
                n_part.connected      = (r_part.first_root == r_part.second_root);
                n_part.first_set_size = r_s1;
                if (r_union && r_part.first_root != r_part.second_root) begin
                    // smaller tree goes under the larger, ties to the first root
                    s_we  = 1'b1;
                    p_we  = 1'b1;
                    s_wdata = sum;
                    if (r_s1 < s_rdata) begin
                        s_waddr = r_part.second_root;
                        p_waddr = r_part.first_root;
                        p_wdata = r_part.second_root;
                    end else begin
                        s_waddr = r_part.first_root;
                        p_waddr = r_part.second_root;
                        p_wdata = r_part.first_root;
                    end
                    n_part.first_set_size = sum;
                    n_single = r_single - CNT_W'(r_s1 == CNT_W'(1))
                               - CNT_W'(s_rdata == CNT_W'(1));
                    n_comp   = r_comp - CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (r_sweep == r_target) begin
                    n_used   = r_target;
                    n_comp   = r_target;
                    n_single = r_target;
                    n_state  = S_DONE;
                end else begin
                    p_we    = 1'b1;
                    p_waddr = r_sweep[IDX_W-1:0];
                    p_wdata = r_sweep[IDX_W-1:0];
                    s_we    = 1'b1;
                    s_waddr = r_sweep[IDX_W-1:0];
                    s_wdata = CNT_W'(1);
                    n_sweep = r_sweep + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, r_part.error, r_part.new_element, multi, r_comp,
                                 r_part.first_set_size, r_part.connected,
                                 r_part.second_root, r_part.first_root};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/dsu_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
